// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion shorthands for the PWM calculator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdc_pkg
// Field widths and fixed constants of the PWM period/duty calculator.
// ----------------------------------------------------------------------------
package pdc_pkg;

    localparam int FREQ_W  = 19;
    localparam int DUTY_W  = 10;
    localparam int COUNT_W = 12;
    localparam int EXP_W   = 4;

    localparam logic [DUTY_W-1:0] DUTY_MIN   = 10'd1;
    localparam logic [DUTY_W-1:0] DUTY_MAX   = 10'd999;
    localparam int                DUTY_SCALE = 1000;

    typedef logic [FREQ_W-1:0]  freq_t;
    typedef logic [DUTY_W-1:0]  duty_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [EXP_W-1:0]   exp_t;

endpackage

// ===== rtl/pdc_divider.sv =====
// ----------------------------------------------------------------------------
// pdc_divider
// Pipelined restoring divider: REF_CLOCK_HZ / freq, one quotient bit per stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdc_divider
    import pdc_pkg::*;
#(
    parameter int unsigned REF_CLOCK_HZ = 96000000,
    parameter int          RW           = 27
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic          in_valid,
    input  freq_t         in_freq,
    input  duty_t         in_duty,
    output logic          out_valid,
    output logic [RW-1:0] out_quot,
    output duty_t         out_duty
);

    localparam logic [RW-1:0] REF_VEC = RW'(REF_CLOCK_HZ);

    logic          vld_reg  [RW];
    freq_t         rem_reg  [RW];
    logic [RW-1:0] quot_reg [RW];
    freq_t         div_reg  [RW];
    duty_t         duty_reg [RW];

    for (genvar i = 0; i < RW; i++) begin : g_stage
        logic          v_in;
        freq_t         rem_in;
        logic [RW-1:0] quot_in;
        freq_t         div_in;
        duty_t         duty_in;
        logic [FREQ_W:0] trial;
        logic          fits;

        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign quot_in = '0;
            assign div_in  = in_freq;
            assign duty_in = in_duty;
        end
        else begin : g_next
            assign v_in    = vld_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign quot_in = quot_reg[i-1];
            assign div_in  = div_reg[i-1];
            assign duty_in = duty_reg[i-1];
        end

        // shift in the next dividend bit, MSB first
        assign trial = {rem_in, REF_VEC[RW-1-i]};
        assign fits  = (trial >= {1'b0, div_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[i]  <= fits ? FREQ_W'(trial - {1'b0, div_in}) : trial[FREQ_W-1:0];
                quot_reg[i] <= RW'({quot_in, fits});
                div_reg[i]  <= div_in;
                duty_reg[i] <= duty_in;
            end
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign out_quot  = quot_reg[RW-1];
    assign out_duty  = duty_reg[RW-1];

    `ASSERT_IMPLY(a_rem_below_div, clk, rst_n, vld_reg[RW-1], rem_reg[RW-1] < div_reg[RW-1])
    `ASSERT_NEXT(a_out_valid_moves, clk, rst_n, vld_reg[RW-2] && advance, out_valid)
    `ASSERT_NEXT(a_out_valid_holds, clk, rst_n, out_valid && !advance, out_valid)

endmodule

// ===== rtl/pdc_split.sv =====
// ----------------------------------------------------------------------------
// pdc_split
// Exponent search, steps per period, duty scaling and high/low split.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdc_split
    import pdc_pkg::*;
#(
    parameter int MAX_STEPS = 4096,
    parameter int RW        = 27
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic          in_valid,
    input  logic [RW-1:0] in_quot,
    input  duty_t         in_duty,
    output logic          out_valid,
    output count_t        out_high,
    output count_t        out_low,
    output exp_t          out_exp
);

    localparam int EW = $clog2(RW + 1);
    localparam int SW = $clog2(MAX_STEPS);
    localparam int PW = SW + DUTY_W;
    localparam int K  = PW + $clog2(DUTY_SCALE);
    localparam longint unsigned RECIP = ((64'd1 << K) + 64'(DUTY_SCALE - 1)) / 64'(DUTY_SCALE);
    localparam int RCW = $clog2(RECIP + 1);
    localparam int MW  = PW + RCW;

    localparam logic [RW-1:0]  M_VEC     = RW'(MAX_STEPS);
    localparam logic [SW:0]    M_EXT     = (SW+1)'(MAX_STEPS);
    localparam logic [RCW-1:0] RECIP_VEC = RCW'(RECIP);

    // stage 1: exponent
    logic          v1_reg;
    logic [EW-1:0] expo_reg;
    logic [RW-1:0] quot1_reg;
    duty_t         duty1_reg;
    // stage 2: steps
    logic          v2_reg;
    logic [SW-1:0] steps2_reg;
    duty_t         duty2_reg;
    logic [EW-1:0] expo2_reg;
    // stage 3: steps * duty
    logic          v3_reg;
    logic [PW-1:0] prod_reg;
    logic [SW-1:0] steps3_reg;
    logic [EW-1:0] expo3_reg;
    // stage 4: / 1000
    logic          v4_reg;
    logic [SW-1:0] hi_reg;
    logic [SW-1:0] steps4_reg;
    logic [EW-1:0] expo4_reg;
    // stage 5: output
    logic          v5_reg;
    count_t        high_reg;
    count_t        low_reg;
    exp_t          exp_reg;

    logic [EW-1:0] expo_next;
    logic [RW-1:0] shifted;
    logic [MW-1:0] scaled;
    logic [SW-1:0] hi1;
    count_t        steps12;
    count_t        hi12;
    count_t        lo12;
    logic [SW:0]   steps_ext;

    // smallest e with (quot >> e) < MAX_STEPS; compares are monotone in e
    always_comb
    begin
        expo_next = '0;
        for (int e = 0; e < RW; e++)
        begin
            if ((in_quot >> e) >= M_VEC)
            begin
                expo_next = EW'(e + 1);
            end
        end
    end

    assign shifted = quot1_reg >> expo_reg;
    assign scaled  = MW'(prod_reg) * MW'(RECIP_VEC);

    always_comb
    begin
        hi1     = (hi_reg == '0) ? SW'(1) : hi_reg;
        steps12 = COUNT_W'(steps4_reg);
        if (hi1 == steps4_reg)
        begin
            hi12 = steps12 - COUNT_W'(1);
            lo12 = COUNT_W'(1);
        end
        else
        begin
            hi12 = COUNT_W'(hi1);
            lo12 = steps12 - COUNT_W'(hi1);
        end
    end

    assign steps_ext = {1'b0, steps2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            expo_reg   <= expo_next;
            quot1_reg  <= in_quot;
            duty1_reg  <= in_duty;

            steps2_reg <= shifted[SW-1:0];
            duty2_reg  <= duty1_reg;
            expo2_reg  <= expo_reg;

            prod_reg   <= PW'(steps2_reg) * PW'(duty2_reg);
            steps3_reg <= steps2_reg;
            expo3_reg  <= expo2_reg;

            hi_reg     <= scaled[K +: SW];
            steps4_reg <= steps3_reg;
            expo4_reg  <= expo3_reg;

            high_reg   <= hi12 - COUNT_W'(1);
            low_reg    <= lo12 - COUNT_W'(1);
            exp_reg    <= EXP_W'(expo4_reg);
        end
    end

    assign out_valid = v5_reg;
    assign out_high  = high_reg;
    assign out_low   = low_reg;
    assign out_exp   = exp_reg;

    `ASSERT_IMPLY(a_steps_range, clk, rst_n, v2_reg, steps_ext < M_EXT)
    `ASSERT_IMPLY(a_hi_bound, clk, rst_n, v4_reg, hi_reg <= steps4_reg)
    `ASSERT_NEXT(a_valid_moves, clk, rst_n, v3_reg && advance, v4_reg)

endmodule

// ===== rtl/pwm_period_duty_calculator.sv =====
// ----------------------------------------------------------------------------
// pwm_period_duty_calculator
// Turns a frequency / duty request into a clock divider exponent and
// high/low phase counts.
// ----------------------------------------------------------------------------
//  channel  | signals                                          | dir
//  ---------+--------------------------------------------------+-----
//  request  | req_valid, req_ready, target_frequency,          | in
//           | duty_permille                                    |
//  response | rsp_valid, rsp_ready, high_count_minus_one,      | out
//           | low_count_minus_one, divider_exponent            |
//
//  One item per cycle while the output is not stalled. Each item passes the
//  input register, the one-bit-per-stage divider, then the split stages.
//  Reset clears only the valid bits; no state links items.
//  A stall at rsp_ready freezes the whole pipeline, so req_ready drops
//  only while a result is held at the output.
// ----------------------------------------------------------------------------
module pwm_period_duty_calculator
    import pdc_pkg::*;
#(
    parameter int unsigned REF_CLOCK_HZ = 96000000,
    parameter int          MAX_STEPS    = 4096
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_ready,
    input  freq_t  target_frequency,
    input  duty_t  duty_permille,
    output logic   rsp_valid,
    input  logic   rsp_ready,
    output count_t high_count_minus_one,
    output count_t low_count_minus_one,
    output exp_t   divider_exponent
);

    localparam int RW = $clog2(REF_CLOCK_HZ + 1);

    logic          advance;
    logic          v0_reg;
    freq_t         freq_reg;
    duty_t         duty_reg;
    freq_t         freq_next;
    duty_t         duty_next;
    logic          div_valid;
    logic [RW-1:0] div_quot;
    duty_t         div_duty;

    assign advance   = !rsp_valid || rsp_ready;
    assign req_ready = advance;

    always_comb
    begin
        freq_next = (target_frequency == '0) ? FREQ_W'(1) : target_frequency;
        if (duty_permille < DUTY_MIN)
        begin
            duty_next = DUTY_MIN;
        end
        else if (duty_permille > DUTY_MAX)
        begin
            duty_next = DUTY_MAX;
        end
        else
        begin
            duty_next = duty_permille;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (advance)
        begin
            v0_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            freq_reg <= freq_next;
            duty_reg <= duty_next;
        end
    end

    pdc_divider #(
        .REF_CLOCK_HZ (REF_CLOCK_HZ),
        .RW           (RW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (v0_reg),
        .in_freq   (freq_reg),
        .in_duty   (duty_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_duty  (div_duty)
    );

    pdc_split #(
        .MAX_STEPS (MAX_STEPS),
        .RW        (RW)
    ) u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (div_valid),
        .in_quot   (div_quot),
        .in_duty   (div_duty),
        .out_valid (rsp_valid),
        .out_high  (high_count_minus_one),
        .out_low   (low_count_minus_one),
        .out_exp   (divider_exponent)
    );

endmodule
